@@ hdl/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// bis_pkg - shared types and constants of the bilinear image scaler
// Field widths, pixel store geometry, register indexes and opcodes.
// ----------------------------------------------------------------------------
package bis_pkg;

   // store geometry
   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int COORD_W    = 9;                       // col and row fields
   localparam int NUM_BANKS  = 4;                       // row parity x col parity
   localparam int BANK_IDX_W = 2;
   localparam int BANK_AW    = 2 * (COORD_W - 1);
   localparam int BANK_DEPTH = 1 << BANK_AW;

   // pixel
   localparam int NUM_CH = 3;
   localparam int CH_W   = 8;
   typedef logic [NUM_CH-1:0][CH_W-1:0] pix_type;       // red in the low byte

   // configuration
   localparam int SIZE_W = 10;
   localparam int STEP_W = 26;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 4;
   localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [1:0] REG_X_STEP     = 2'd2;
   localparam logic [1:0] REG_Y_STEP     = 2'd3;
   localparam logic [SIZE_W-1:0] SRC_WIDTH_RST  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] SRC_HEIGHT_RST = SIZE_W'(MAX_HEIGHT);
   localparam logic [STEP_W-1:0] STEP_RST       = STEP_W'(65536);

   // fixed point
   localparam int FRAC_W  = 16;
   localparam int POS_W   = COORD_W + STEP_W;           // col*step, 19.16
   localparam int RAW_W   = POS_W - FRAC_W;             // integer part
   localparam int WT_W    = FRAC_W + 1;                 // weight up to 1.0
   localparam int WPROD_W = 2 * FRAC_W + 1;             // wx*wy up to 2^32
   localparam int PROD_W  = CH_W + WPROD_W;
   localparam int ACC_W   = PROD_W + 2;

   // item kinds
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   // stream widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

endpackage

@@ hdl/bilinear_image_scaler.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_scaler - pipelined bilinear resize of a stored RGB frame
// Loads write source pixels into a banked store; queries return the blended
// color of one destination pixel.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+------------------------------------
//  req_*     | in  | tvalid / tready       | tuser: func; tdata: col,row,rgb
//  rsp_*     | out | tvalid / tready       | tdata: red, green, blue
//  csr_*     | in  | psel/penable/pwrite   | 4 regs at 0x0,0x4,0x8,0xC, 32 bit
//
//  One item per clock sustained unless rsp stalls; loads and queries mix freely. A query
//  takes eight register stages from its transfer to a valid result.
//  The four neighbor reads come from four store banks (row parity x col
//  parity), one read and one write port each; that port count sets the rate.
//  Each stage has its own valid bit and moves when the stage ahead is empty
//  or moving, so bubbles close up while rsp is stalled.
//  Synchronous reset clears valids and config registers; the store is not cleared.
//
module bilinear_image_scaler (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bis_pkg::REQ_DATA_W-1:0]    req_tdata,  // col, row, red, green, blue
   input  logic                              req_tuser,  // func
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bis_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // red, green, blue
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bis_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [bis_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [bis_pkg::DATA_W-1:0]        csr_prdata,
   output logic                              csr_pready
);

   // ---------------------------------------------------------------- types
   typedef struct packed {
      logic                          func;
      logic [bis_pkg::COORD_W-1:0]   col;
      logic [bis_pkg::COORD_W-1:0]   row;
      bis_pkg::pix_type              pix;
   } a_type;

   typedef struct packed {
      logic                          func;
      logic [bis_pkg::COORD_W-1:0]   col;
      logic [bis_pkg::COORD_W-1:0]   row;
      bis_pkg::pix_type              pix;
      logic [bis_pkg::POS_W-1:0]     sx;
      logic [bis_pkg::POS_W-1:0]     sy;
   } b_type;

   // neighbor parities pick banks after the read
   typedef struct packed {
      logic                          x1b;
      logic                          x2b;
      logic                          y1b;
      logic                          y2b;
      logic [bis_pkg::FRAC_W-1:0]    dx;
      logic [bis_pkg::FRAC_W-1:0]    dy;
   } sel_type;

   typedef struct packed {
      logic                                            func;
      logic [bis_pkg::BANK_IDX_W-1:0]                  wbank;
      logic [bis_pkg::BANK_AW-1:0]                     waddr;
      bis_pkg::pix_type                                pix;
      logic [bis_pkg::NUM_BANKS-1:0][bis_pkg::BANK_AW-1:0] raddr;
      sel_type                                         sel;
   } c_type;

   typedef struct packed {
      bis_pkg::pix_type [3:0]                  p;      // p11, p12, p21, p22
      logic [3:0][bis_pkg::WPROD_W-1:0]        w;      // matching weights
   } e_type;

   typedef logic [bis_pkg::NUM_CH-1:0][3:0][bis_pkg::PROD_W-1:0] f_type;
   typedef logic [bis_pkg::NUM_CH-1:0][1:0][bis_pkg::PROD_W:0]   g_type;

   // ---------------------------------------------------------------- config
   logic                         csr_wr;
   logic [bis_pkg::SIZE_W-1:0]   src_width_ff,  src_width_in;
   logic [bis_pkg::SIZE_W-1:0]   src_height_ff, src_height_in;
   logic [bis_pkg::STEP_W-1:0]   x_step_ff,     x_step_in;
   logic [bis_pkg::STEP_W-1:0]   y_step_ff,     y_step_in;
   logic [bis_pkg::SIZE_W-1:0]   sw_eff, sh_eff, sw_m1, sh_m1;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      x_step_in     = x_step_ff;
      y_step_in     = y_step_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            bis_pkg::REG_SRC_WIDTH:  src_width_in  = csr_pwdata[bis_pkg::SIZE_W-1:0];
            bis_pkg::REG_SRC_HEIGHT: src_height_in = csr_pwdata[bis_pkg::SIZE_W-1:0];
            bis_pkg::REG_X_STEP:     x_step_in     = csr_pwdata[bis_pkg::STEP_W-1:0];
            bis_pkg::REG_Y_STEP:     y_step_in     = csr_pwdata[bis_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         bis_pkg::REG_SRC_WIDTH:  csr_prdata = bis_pkg::DATA_W'(src_width_ff);
         bis_pkg::REG_SRC_HEIGHT: csr_prdata = bis_pkg::DATA_W'(src_height_ff);
         bis_pkg::REG_X_STEP:     csr_prdata = bis_pkg::DATA_W'(x_step_ff);
         bis_pkg::REG_Y_STEP:     csr_prdata = bis_pkg::DATA_W'(y_step_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= bis_pkg::SRC_WIDTH_RST;
         src_height_ff <= bis_pkg::SRC_HEIGHT_RST;
         x_step_ff     <= bis_pkg::STEP_RST;
         y_step_ff     <= bis_pkg::STEP_RST;
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         x_step_ff     <= x_step_in;
         y_step_ff     <= y_step_in;
      end
   end

   // zero acts as one, oversize acts as the store size
   function automatic logic [bis_pkg::SIZE_W-1:0] size_clamp(
      input logic [bis_pkg::SIZE_W-1:0] v,
      input logic [bis_pkg::SIZE_W-1:0] maxv
   );
      logic [bis_pkg::SIZE_W-1:0] r;
      r = v;
      if (v == '0)
         r = bis_pkg::SIZE_W'(1);
      else if (v > maxv)
         r = maxv;
      return r;
   endfunction

   assign sw_eff = size_clamp(src_width_ff,  bis_pkg::SRC_WIDTH_RST);
   assign sh_eff = size_clamp(src_height_ff, bis_pkg::SRC_HEIGHT_RST);
   assign sw_m1  = sw_eff - bis_pkg::SIZE_W'(1);
   assign sh_m1  = sh_eff - bis_pkg::SIZE_W'(1);

   // ---------------------------------------------------------------- flow
   // stage a: input, b: scaled position, c: store address, d: store data,
   // e: neighbors and weights, f: products, g: pair sums, h: result
   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff, f_vld_ff, g_vld_ff, h_vld_ff;
   logic a_vld_in, b_vld_in, c_vld_in, d_vld_in, e_vld_in, f_vld_in, g_vld_in, h_vld_in;
   logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g, rdy_h;

   assign rdy_h = !h_vld_ff || rsp_tready;
   assign rdy_g = !g_vld_ff || rdy_h;
   assign rdy_f = !f_vld_ff || rdy_g;
   assign rdy_e = !e_vld_ff || rdy_f;
   assign rdy_d = !d_vld_ff || rdy_e;
   assign rdy_c = !c_vld_ff || rdy_d;
   assign rdy_b = !b_vld_ff || rdy_c;
   assign rdy_a = !a_vld_ff || rdy_b;

   assign req_tready = rdy_a;

   // loads leave the pipe once written to the store
   assign a_vld_in = rdy_a ? req_tvalid : a_vld_ff;
   assign b_vld_in = rdy_b ? a_vld_ff   : b_vld_ff;
   assign c_vld_in = rdy_c ? b_vld_ff   : c_vld_ff;
   assign d_vld_in = rdy_d ? (c_vld_ff && c_ff.func == bis_pkg::FUNC_QUERY) : d_vld_ff;
   assign e_vld_in = rdy_e ? d_vld_ff   : e_vld_ff;
   assign f_vld_in = rdy_f ? e_vld_ff   : f_vld_ff;
   assign g_vld_in = rdy_g ? f_vld_ff   : g_vld_ff;
   assign h_vld_in = rdy_h ? g_vld_ff   : h_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
         d_vld_ff <= d_vld_in;
         e_vld_ff <= e_vld_in;
         f_vld_ff <= f_vld_in;
         g_vld_ff <= g_vld_in;
         h_vld_ff <= h_vld_in;
      end
   end

   // ---------------------------------------------------------------- payload
   a_type            a_ff, a_in;
   b_type            b_ff, b_in;
   c_type            c_ff, c_in;
   sel_type          d_ff, d_in;
   e_type            e_ff, e_in;
   f_type            f_ff, f_in;
   g_type            g_ff, g_in;
   bis_pkg::pix_type h_ff, h_in;
   bis_pkg::pix_type rd_ff [bis_pkg::NUM_BANKS];

   // stage a: unpack the transfer
   always_comb begin
      a_in.func = req_tuser;
      a_in.col  = req_tdata[bis_pkg::COORD_W-1:0];
      a_in.row  = req_tdata[2*bis_pkg::COORD_W-1:bis_pkg::COORD_W];
      a_in.pix  = req_tdata[2*bis_pkg::COORD_W +: bis_pkg::NUM_CH*bis_pkg::CH_W];
   end

   // stage b: source position in 19.16
   always_comb begin
      b_in.func = a_ff.func;
      b_in.col  = a_ff.col;
      b_in.row  = a_ff.row;
      b_in.pix  = a_ff.pix;
      b_in.sx   = a_ff.col * x_step_ff;
      b_in.sy   = a_ff.row * y_step_ff;
   end

   // stage c: clamp, far neighbor, per-bank read address
   logic [bis_pkg::RAW_W-1:0]   x1_raw, y1_raw;
   logic [bis_pkg::COORD_W-1:0] x1, x2, y1, y2;
   logic [bis_pkg::SIZE_W-1:0]  x1_inc, y1_inc;
   logic [bis_pkg::COORD_W-1:0] col_sel [bis_pkg::NUM_BANKS];
   logic [bis_pkg::COORD_W-1:0] row_sel [bis_pkg::NUM_BANKS];

   always_comb begin
      x1_raw = b_ff.sx[bis_pkg::POS_W-1:bis_pkg::FRAC_W];
      y1_raw = b_ff.sy[bis_pkg::POS_W-1:bis_pkg::FRAC_W];
      x1 = (x1_raw > bis_pkg::RAW_W'(sw_m1)) ? sw_m1[bis_pkg::COORD_W-1:0]
                                             : x1_raw[bis_pkg::COORD_W-1:0];
      y1 = (y1_raw > bis_pkg::RAW_W'(sh_m1)) ? sh_m1[bis_pkg::COORD_W-1:0]
                                             : y1_raw[bis_pkg::COORD_W-1:0];
      x1_inc = {1'b0, x1} + bis_pkg::SIZE_W'(1);
      y1_inc = {1'b0, y1} + bis_pkg::SIZE_W'(1);
      x2 = (x1_inc < sw_eff) ? x1_inc[bis_pkg::COORD_W-1:0] : sw_m1[bis_pkg::COORD_W-1:0];
      y2 = (y1_inc < sh_eff) ? y1_inc[bis_pkg::COORD_W-1:0] : sh_m1[bis_pkg::COORD_W-1:0];

      c_in.func  = b_ff.func;
      c_in.pix   = b_ff.pix;
      c_in.wbank = {b_ff.row[0], b_ff.col[0]};
      c_in.waddr = {b_ff.row[bis_pkg::COORD_W-1:1], b_ff.col[bis_pkg::COORD_W-1:1]};
      // each bank serves whichever neighbor column / row has its parity
      for (int b = 0; b < bis_pkg::NUM_BANKS; b++) begin
         col_sel[b] = (x1[0] == b[0]) ? x1 : x2;
         row_sel[b] = (y1[0] == b[1]) ? y1 : y2;
         c_in.raddr[b] = {row_sel[b][bis_pkg::COORD_W-1:1],
                          col_sel[b][bis_pkg::COORD_W-1:1]};
      end
      c_in.sel.x1b = x1[0];
      c_in.sel.x2b = x2[0];
      c_in.sel.y1b = y1[0];
      c_in.sel.y2b = y2[0];
      c_in.sel.dx  = b_ff.sx[bis_pkg::FRAC_W-1:0];
      c_in.sel.dy  = b_ff.sy[bis_pkg::FRAC_W-1:0];
   end

   // stage d: pixel store, four banks, write and read in the same stage
   // so a query always sees every earlier load
   logic mem_we;
   assign mem_we = rdy_d && c_vld_ff && (c_ff.func == bis_pkg::FUNC_LOAD);
   assign d_in   = c_ff.sel;

   for (genvar gb = 0; gb < bis_pkg::NUM_BANKS; gb++) begin : g_bank
      bis_pkg::pix_type bank_mem [bis_pkg::BANK_DEPTH];
      always_ff @(posedge clock) begin
         if (mem_we && c_ff.wbank == bis_pkg::BANK_IDX_W'(gb))
            bank_mem[c_ff.waddr] <= c_ff.pix;
         if (rdy_d)
            rd_ff[gb] <= bank_mem[c_ff.raddr[gb]];
      end
   end

   // stage e: route banks to neighbors, weight products
   logic [bis_pkg::WT_W-1:0]     wx1, wx2, wy1, wy2;
   logic [2*bis_pkg::WT_W-1:0]   wfull [4];

   always_comb begin
      wx2 = {1'b0, d_ff.dx};
      wy2 = {1'b0, d_ff.dy};
      wx1 = (bis_pkg::WT_W'(1) << bis_pkg::FRAC_W) - wx2;
      wy1 = (bis_pkg::WT_W'(1) << bis_pkg::FRAC_W) - wy2;
      wfull[0] = wx1 * wy1;
      wfull[1] = wx2 * wy1;
      wfull[2] = wx1 * wy2;
      wfull[3] = wx2 * wy2;
      e_in.p[0] = rd_ff[{d_ff.y1b, d_ff.x1b}];
      e_in.p[1] = rd_ff[{d_ff.y1b, d_ff.x2b}];
      e_in.p[2] = rd_ff[{d_ff.y2b, d_ff.x1b}];
      e_in.p[3] = rd_ff[{d_ff.y2b, d_ff.x2b}];
      for (int k = 0; k < 4; k++)
         e_in.w[k] = wfull[k][bis_pkg::WPROD_W-1:0];
   end

   // stage f: pixel times weight
   always_comb begin
      for (int c = 0; c < bis_pkg::NUM_CH; c++)
         for (int k = 0; k < 4; k++)
            f_in[c][k] = e_ff.p[k][c] * e_ff.w[k];
   end

   // stage g: pair sums
   always_comb begin
      for (int c = 0; c < bis_pkg::NUM_CH; c++) begin
         g_in[c][0] = {1'b0, f_ff[c][0]} + {1'b0, f_ff[c][1]};
         g_in[c][1] = {1'b0, f_ff[c][2]} + {1'b0, f_ff[c][3]};
      end
   end

   // stage h: final sum, round half up, drop the 32 fraction bits
   logic [bis_pkg::ACC_W-1:0] acc [bis_pkg::NUM_CH];

   always_comb begin
      for (int c = 0; c < bis_pkg::NUM_CH; c++) begin
         acc[c]  = {1'b0, g_ff[c][0]} + {1'b0, g_ff[c][1]}
                 + (bis_pkg::ACC_W'(1) << (2*bis_pkg::FRAC_W - 1));
         h_in[c] = acc[c][2*bis_pkg::FRAC_W +: bis_pkg::CH_W];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) a_ff <= a_in;
      if (rdy_b) b_ff <= b_in;
      if (rdy_c) c_ff <= c_in;
      if (rdy_d) d_ff <= d_in;
      if (rdy_e) e_ff <= e_in;
      if (rdy_f) f_ff <= f_in;
      if (rdy_g) g_ff <= g_in;
      if (rdy_h) h_ff <= h_in;
   end

   assign rsp_tvalid = h_vld_ff;
   assign rsp_tdata  = h_ff;

endmodule

@@ hdl/bis_checker.sv @@
// ----------------------------------------------------------------------------
// bis_checker - port-level checks for the bilinear image scaler
// Watches the stream and register ports over time.
// ----------------------------------------------------------------------------
module bis_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [bis_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bis_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [bis_pkg::ADDR_W-1:0]      csr_paddr,
   input logic [bis_pkg::DATA_W-1:0]      csr_pwdata,
   input logic [bis_pkg::DATA_W-1:0]      csr_prdata,
   input logic                            csr_pready
);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // input only backs up when every stage is full and the output is stalled
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while pipeline could move");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // x step register reads back what was written
   a_step_readback: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_pready
       && csr_paddr[3:2] == bis_pkg::REG_X_STEP)
      |=> (csr_paddr[3:2] != bis_pkg::REG_X_STEP
           || csr_prdata == {{(bis_pkg::DATA_W-bis_pkg::STEP_W){1'b0}},
                             $past(csr_pwdata[bis_pkg::STEP_W-1:0])}))
      else $error("x step readback mismatch");

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (.*);
